// ----- rtl/cbl_pkg.sv -----
// shared types and constants for the clipped bresenham line rasterizer
// used by cbl_front, cbl_queue, cbl_back and the top level
`default_nettype none

package cbl_pkg;

  localparam int COORD_W         = 7;
  localparam int DELTA_W         = 6;
  localparam int IDX_W           = 10;
  localparam int ERR_W           = 9;
  localparam int RASTER_SIZE_DEF = 24;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic signed [COORD_W-1:0] COORD_LOW  = -7'sd16;
  localparam logic signed [COORD_W-1:0] COORD_HIGH = 7'sd47;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one classified segment, ready for the walker
  typedef struct packed {
    coord_t              x0;
    coord_t              y0;
    logic [DELTA_W-1:0]  dmaj;
    logic [DELTA_W-1:0]  dmin;
    logic signed [1:0]   sx;
    logic signed [1:0]   sy;
    logic                x_major;
  } seg_t;

endpackage

`default_nettype wire

// ----- rtl/cbl_front.sv -----
// front end: clamps endpoints, finds deltas, step signs and the major axis
// depends on cbl_pkg
`default_nettype none

module cbl_front
  import cbl_pkg::*;
(
  input  coord_t x_start_i,
  input  coord_t y_start_i,
  input  coord_t x_end_i,
  input  coord_t y_end_i,
  output seg_t   seg_o
);

  function automatic coord_t clamp(input coord_t v);
    coord_t r;
    r = v;
    if (v < COORD_LOW) r = COORD_LOW;
    else if (v > COORD_HIGH) r = COORD_HIGH;
    return r;
  endfunction

  coord_t                    xs, ys, xe, ye;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic [DELTA_W-1:0]        mdx, mdy;

  always_comb begin
    xs  = clamp(x_start_i);
    ys  = clamp(y_start_i);
    xe  = clamp(x_end_i);
    ye  = clamp(y_end_i);
    dx  = {xe[COORD_W-1], xe} - {xs[COORD_W-1], xs};
    dy  = {ye[COORD_W-1], ye} - {ys[COORD_W-1], ys};
    adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    // clamped range keeps both deltas within 63
    mdx = adx[DELTA_W-1:0];
    mdy = ady[DELTA_W-1:0];

    seg_o.x0      = xs;
    seg_o.y0      = ys;
    seg_o.sx      = dx[COORD_W] ? -2'sd1 : ((dx != '0) ? 2'sd1 : 2'sd0);
    seg_o.sy      = dy[COORD_W] ? -2'sd1 : ((dy != '0) ? 2'sd1 : 2'sd0);
    seg_o.x_major = (mdx >= mdy);
    seg_o.dmaj    = seg_o.x_major ? mdx : mdy;
    seg_o.dmin    = seg_o.x_major ? mdy : mdx;
  end

endmodule

`default_nettype wire

// ----- rtl/cbl_queue.sv -----
// short fifo of classified segments between front end and walker
// depends on cbl_pkg
`default_nettype none

module cbl_queue
  import cbl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seg_t push_seg_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output seg_t pop_seg_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  seg_t               mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign full_o    = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_seg_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? bump(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_seg_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cbl_back.sv -----
// back end: bresenham walker, one pixel per cycle into an output register while the output is not stalled
// depends on cbl_pkg
`default_nettype none

module cbl_back
  import cbl_pkg::*;
#(
  parameter int RASTER_SIZE = RASTER_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             seg_valid_i,
  input  seg_t             seg_i,
  output logic             seg_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output coord_t           pixel_x_o,
  output coord_t           pixel_y_o,
  output logic             inside_res_o,
  output logic [IDX_W-1:0] mask_index_o,
  output logic             last_pixel_o
);

  localparam logic signed [COORD_W-1:0] SIZE_C = COORD_W'(RASTER_SIZE);

  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  coord_t                   x_q, x_d, y_q, y_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic [DELTA_W-1:0]       cnt_q, cnt_d, dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic signed [1:0]        sx_q, sx_d, sy_q, sy_d;
  logic                     xmaj_q, xmaj_d;

  coord_t                   px_q, py_q;
  logic                     inside_q, last_q;
  logic [IDX_W-1:0]         idx_q;

  logic                     emit, load, in_mask, minor_step;
  coord_t                   stx, sty;
  logic [IDX_W-1:0]         idx;
  logic signed [ERR_W:0]    err_next;

  assign emit = busy_q && (!out_valid_q || out_ready_i);
  assign load = !busy_q && seg_valid_i;
  assign seg_pop_o = load;

  always_comb begin
    in_mask = (x_q >= 0) && (x_q < SIZE_C) && (y_q >= 0) && (y_q < SIZE_C);
    idx     = IDX_W'({y_q[COORD_W-2:0]} * IDX_W'(RASTER_SIZE))
              + IDX_W'(x_q[COORD_W-2:0]);
    if (!in_mask) idx = '0;

    stx        = {{(COORD_W-2){sx_q[1]}}, sx_q};
    sty        = {{(COORD_W-2){sy_q[1]}}, sy_q};
    minor_step = (err_q > 0);
    err_next   = {err_q[ERR_W-1], err_q} + (ERR_W+1)'({dmin_q, 1'b0})
                 - (minor_step ? (ERR_W+1)'({dmaj_q, 1'b0}) : '0);

    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    x_d    = x_q;    y_d    = y_q;    err_d  = err_q;   cnt_d = cnt_q;
    dmaj_d = dmaj_q; dmin_d = dmin_q; sx_d   = sx_q;    sy_d  = sy_q;
    xmaj_d = xmaj_q;

    if (out_ready_i) out_valid_d = 1'b0;

    if (load) begin
      busy_d = 1'b1;
      x_d    = seg_i.x0;
      y_d    = seg_i.y0;
      cnt_d  = seg_i.dmaj;
      dmaj_d = seg_i.dmaj;
      dmin_d = seg_i.dmin;
      sx_d   = seg_i.sx;
      sy_d   = seg_i.sy;
      xmaj_d = seg_i.x_major;
      // initial decision term 2*minor - major
      err_d  = $signed({2'b00, seg_i.dmin, 1'b0}) - $signed({3'b000, seg_i.dmaj});
    end else if (emit) begin
      out_valid_d = 1'b1;
      err_d       = err_next[ERR_W-1:0];
      cnt_d       = cnt_q - DELTA_W'(1);
      if (cnt_q == '0) busy_d = 1'b0;
      if (xmaj_q) begin
        x_d = x_q + stx;
        if (minor_step) y_d = y_q + sty;
      end else begin
        y_d = y_q + sty;
        if (minor_step) x_d = x_q + stx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;    y_q    <= y_d;    err_q <= err_d;  cnt_q <= cnt_d;
    dmaj_q <= dmaj_d; dmin_q <= dmin_d; sx_q  <= sx_d;   sy_q  <= sy_d;
    xmaj_q <= xmaj_d;
    if (emit) begin
      px_q     <= x_q;
      py_q     <= y_q;
      inside_q <= in_mask;
      idx_q    <= idx;
      last_q   <= (cnt_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign inside_res_o = inside_q;
  assign mask_index_o = idx_q;
  assign last_pixel_o = last_q;

endmodule

`default_nettype wire

// ----- rtl/clipped_bresenham_line.sv -----
// top level of the clipped bresenham line rasterizer
// depends on cbl_pkg, cbl_front, cbl_queue, cbl_back
//
//   channel  beat                               handshake
//   in       x_start, y_start, x_end, y_end     in_valid_i / in_ready_o
//   out      pixel_x, pixel_y, inside_res,      out_valid_o / out_ready_i
//            mask_index, last_pixel
//
// a segment is loaded into the walker, which then emits one pixel per cycle
// while the output is not stalled, max(|dx|,|dy|) + 1 pixels in all
// segments queue in a two-entry fifo, so the input keeps taking beats
// while the walker works or the output stalls, until the fifo is full
// reset clears the fifo pointers and count, walker busy flag and output valid
`default_nettype none

module clipped_bresenham_line
  import cbl_pkg::*;
#(
  parameter int RASTER_SIZE = RASTER_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  coord_t           x_start_i,
  input  coord_t           y_start_i,
  input  coord_t           x_end_i,
  input  coord_t           y_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output coord_t           pixel_x_o,
  output coord_t           pixel_y_o,
  output logic             inside_res_o,
  output logic [IDX_W-1:0] mask_index_o,
  output logic             last_pixel_o
);

  seg_t front_seg, queue_seg;
  logic q_full, q_valid, q_pop;

  cbl_front u_front (
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .seg_o     (front_seg)
  );

  assign in_ready_o = !q_full;

  cbl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !q_full),
    .push_seg_i (front_seg),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_seg_o  (queue_seg)
  );

  cbl_back #(
    .RASTER_SIZE (RASTER_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_valid_i  (q_valid),
    .seg_i        (queue_seg),
    .seg_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .inside_res_o (inside_res_o),
    .mask_index_o (mask_index_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire
